[rtl/bfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared widths, framing bytes and receiver state codes of the byte frame
// deframer.
// ----------------------------------------------------------------------------
package bfd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int IDX_W  = 6;
	localparam int ST_W   = 3;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ST_W-1:0]   rx_state_t;

	localparam byte_t HEADER_BYTE  = 8'hFE;
	localparam byte_t TRAILER_BYTE = 8'hFF;
	localparam len_t  LEN_RESET    = 7'd5;

	localparam rx_state_t ST_INIT = 3'd0;
	localparam rx_state_t ST_HDR1 = 3'd1;
	localparam rx_state_t ST_HDR2 = 3'd2;
	localparam rx_state_t ST_DATA = 3'd3;
	localparam rx_state_t ST_END1 = 3'd4;
	localparam rx_state_t ST_END2 = 3'd5;

endpackage
`default_nettype wire

[rtl/byte_frame_deframer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// byte_frame_deframer_top
// Header/trailer byte frame deframer with payload store and readout.
// ----------------------------------------------------------------------------
// An ordinary received byte gives one result word through the output register;
// a new byte is taken whenever that register is empty or being drained and no
// readout is running. A byte that completes a frame (FE FE, payload, FF FF)
// starts a readout of the n stored payload bytes from the store, whose read
// data is registered: each entry passes a read state and then a load state,
// and input is held until the readout ends. The store has no reset and needs
// no clearing pass; only entries written by the current frame are read out,
// and no write can occur during a readout.
// ----------------------------------------------------------------------------
module byte_frame_deframer_top #(
	parameter int PAYLOAD_MAX = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  bfd_pkg::len_t        cfg_wdata,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  bfd_pkg::byte_t       rx_byte,
	output logic                 out_valid,
	input  wire                  out_ready,
	output bfd_pkg::byte_t       echo_byte,
	output logic                 frame_done,
	output bfd_pkg::idx_t        payload_index,
	output bfd_pkg::byte_t       payload_byte,
	output logic                 last,
	output logic                 complete_flag,
	output bfd_pkg::rx_state_t   state_code
);

	localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
	localparam bfd_pkg::len_t PMAX = bfd_pkg::len_t'(PAYLOAD_MAX);

	typedef enum logic [1:0] {
		RD_IDLE,
		RD_READ,
		RD_LOAD
	} rd_state_t;

	rd_state_t            rd_state_q;
	logic [AW-1:0]        rd_idx_q;
	logic [AW-1:0]        rd_last_q;
	bfd_pkg::byte_t       hold_byte_q;

	bfd_pkg::len_t        cfg_len_q;
	bfd_pkg::rx_state_t   rx_state_q;
	bfd_pkg::len_t        byte_index_q;
	logic                 done_q;

	logic                 out_valid_q;
	bfd_pkg::byte_t       echo_byte_q;
	logic                 frame_done_q;
	bfd_pkg::idx_t        payload_index_q;
	bfd_pkg::byte_t       payload_byte_q;
	logic                 last_q;
	logic                 complete_q;
	bfd_pkg::rx_state_t   state_code_q;

	logic                 out_free;
	logic                 accept;
	logic                 out_load;
	bfd_pkg::len_t        eff_len;
	bfd_pkg::rx_state_t   st_n;
	bfd_pkg::len_t        idx_n;
	logic                 done_n;
	logic                 completed;
	logic                 st_we;
	logic                 st_re;
	bfd_pkg::byte_t       st_rdata;
	bfd_pkg::len_t        run_len;
	bfd_pkg::len_t        run_last;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (rd_state_q == RD_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign out_load = (accept && !completed) || ((rd_state_q == RD_LOAD) && out_free);

	always_comb begin
		if (cfg_len_q == '0) begin
			eff_len = 7'd1;
		end else if (cfg_len_q > PMAX) begin
			eff_len = PMAX;
		end else begin
			eff_len = cfg_len_q;
		end
	end

	always_comb begin
		st_n      = rx_state_q;
		idx_n     = byte_index_q;
		done_n    = done_q;
		completed = 1'b0;
		st_we     = 1'b0;
		unique case (rx_state_q) inside
			bfd_pkg::ST_INIT, bfd_pkg::ST_HDR1: begin
				if (rx_byte == bfd_pkg::HEADER_BYTE) begin
					idx_n = '0;
					st_n  = bfd_pkg::ST_HDR2;
				end
			end
			bfd_pkg::ST_HDR2: begin
				st_n = (rx_byte == bfd_pkg::HEADER_BYTE) ? bfd_pkg::ST_DATA
				                                         : bfd_pkg::ST_HDR1;
			end
			bfd_pkg::ST_DATA: begin
				if (byte_index_q < PMAX) begin
					st_we = 1'b1;
					idx_n = byte_index_q + 7'd1;
				end
				if (idx_n >= eff_len) begin
					st_n = bfd_pkg::ST_END1;
				end
			end
			bfd_pkg::ST_END1: begin
				st_n = (rx_byte == bfd_pkg::TRAILER_BYTE) ? bfd_pkg::ST_END2
				                                          : bfd_pkg::ST_HDR1;
			end
			bfd_pkg::ST_END2: begin
				if (rx_byte == bfd_pkg::TRAILER_BYTE) begin
					done_n    = 1'b1;
					st_n      = bfd_pkg::ST_INIT;
					completed = 1'b1;
				end else begin
					st_n = bfd_pkg::ST_HDR1;
				end
			end
			default: begin
				st_n = bfd_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		if (byte_index_q == '0) begin
			run_len = 7'd1;
		end else if (byte_index_q > PMAX) begin
			run_len = PMAX;
		end else begin
			run_len = byte_index_q;
		end
		run_last = run_len - 7'd1;
	end

	assign st_re = (rd_state_q == RD_READ);

	bfd_store #(
		.DEPTH (PAYLOAD_MAX),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (accept && st_we),
		.waddr (byte_index_q[AW-1:0]),
		.wdata (rx_byte),
		.re    (st_re),
		.raddr (rd_idx_q),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q       <= bfd_pkg::LEN_RESET;
			rx_state_q      <= bfd_pkg::ST_INIT;
			byte_index_q    <= '0;
			done_q          <= 1'b0;
			rd_state_q      <= RD_IDLE;
			rd_idx_q        <= '0;
			rd_last_q       <= '0;
			hold_byte_q     <= '0;
			out_valid_q     <= 1'b0;
			echo_byte_q     <= '0;
			frame_done_q    <= 1'b0;
			payload_index_q <= '0;
			payload_byte_q  <= '0;
			last_q          <= 1'b0;
			complete_q      <= 1'b0;
			state_code_q    <= bfd_pkg::ST_INIT;
		end else begin
			if (cfg_we) begin
				cfg_len_q <= cfg_wdata;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				rx_state_q   <= st_n;
				byte_index_q <= idx_n;
				done_q       <= done_n;
				if (completed) begin
					rd_state_q  <= RD_READ;
					rd_idx_q    <= '0;
					rd_last_q   <= run_last[AW-1:0];
					hold_byte_q <= rx_byte;
				end else begin
					echo_byte_q     <= rx_byte;
					frame_done_q    <= 1'b0;
					payload_index_q <= '0;
					payload_byte_q  <= '0;
					last_q          <= 1'b1;
					complete_q      <= done_n;
					state_code_q    <= st_n;
				end
			end

			unique case (rd_state_q)
				RD_IDLE: begin
				end
				RD_READ: begin
					rd_state_q <= RD_LOAD;
				end
				RD_LOAD: begin
					if (out_free) begin
						echo_byte_q     <= hold_byte_q;
						frame_done_q    <= 1'b1;
						payload_index_q <= bfd_pkg::idx_t'(rd_idx_q);
						payload_byte_q  <= st_rdata;
						last_q          <= (rd_idx_q == rd_last_q);
						complete_q      <= done_q;
						state_code_q    <= rx_state_q;
						if (rd_idx_q == rd_last_q) begin
							rd_state_q <= RD_IDLE;
						end else begin
							rd_idx_q   <= rd_idx_q + 1'b1;
							rd_state_q <= RD_READ;
						end
					end
				end
				default: begin
					rd_state_q <= RD_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign echo_byte     = echo_byte_q;
	assign frame_done    = frame_done_q;
	assign payload_index = payload_index_q;
	assign payload_byte  = payload_byte_q;
	assign last          = last_q;
	assign complete_flag = complete_q;
	assign state_code    = state_code_q;

endmodule
`default_nettype wire

[rtl/bfd_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_store
// Payload store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfd_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire                 clk,
	input  wire                 we,
	input  wire  [AW-1:0]       waddr,
	input  bfd_pkg::byte_t      wdata,
	input  wire                 re,
	input  wire  [AW-1:0]       raddr,
	output bfd_pkg::byte_t      rdata
);

	bfd_pkg::byte_t mem [DEPTH];
	bfd_pkg::byte_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire
